### src/wepm_pkg.sv
// shared types, constants and weight tables for the windowed ewma position mapper
// no dependencies; every other file uses this package
package wepm_pkg;

	localparam int MAX_SAMPLES_DEF = 10;
	localparam int SAMPLE_BITS_DEF = 14;
	localparam int WEIGHT_W        = 17;
	localparam int WSUM_W          = 21;
	localparam int TAB_N           = 17;
	localparam int TAB_IW          = 5;
	localparam int HALF_W          = 16;
	localparam int OUT_W           = 16;
	localparam int CFG_IDX_W       = 3;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_LEFT_Y     = 3'd0,
		REG_BOTTOM_RIGHT_Y = 3'd1,
		REG_TOP_LEFT_X     = 3'd2,
		REG_BOTTOM_RIGHT_X = 3'd3,
		REG_HALF_HEIGHT    = 3'd4,
		REG_HALF_DEPTH     = 3'd5,
		REG_THREE_D_MODE   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic rot;
	} cell_ctl_t;

	typedef logic [WEIGHT_W-1:0] weight_tab_t [TAB_N];
	typedef logic [WSUM_W-1:0]   wsum_tab_t [TAB_N];

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// 0.9^k in q16, rounded half up at every step
	function automatic weight_tab_t weight_table();
		weight_tab_t t;
		int          w;
		w = 65536;
		for (int k = 0; k < TAB_N; k++) begin
			t[k] = WEIGHT_W'(w);
			w = (w * 9 + 5) / 10;
		end
		return t;
	endfunction

	// running sum of the weights from age 0 up to k
	function automatic wsum_tab_t wsum_table();
		wsum_tab_t t;
		int        w;
		int        s;
		w = 65536;
		s = 0;
		for (int k = 0; k < TAB_N; k++) begin
			s = s + w;
			t[k] = WSUM_W'(s);
			w = (w * 9 + 5) / 10;
		end
		return t;
	endfunction

	localparam weight_tab_t WEIGHT_TAB = weight_table();
	localparam wsum_tab_t   WSUM_TAB   = wsum_table();

endpackage

### src/wepm_if.sv
// channel interfaces: sample input, paddle result output, configuration write
// depends on wepm_pkg for widths
interface wepm_in_if #(parameter int SB = wepm_pkg::SAMPLE_BITS_DEF);
	logic               valid;
	logic               ready;
	logic               tracked;
	logic signed [SB-1:0] hand_x;
	logic signed [SB-1:0] hand_y;
	modport source (output valid, tracked, hand_x, hand_y, input ready);
	modport sink (input valid, tracked, hand_x, hand_y, output ready);
endinterface

interface wepm_out_if;
	logic        valid;
	logic        ready;
	logic signed [wepm_pkg::OUT_W-1:0] paddle_y;
	logic signed [wepm_pkg::OUT_W-1:0] paddle_z;
	logic        depth_updated;
	logic        saturated;
	modport source (output valid, paddle_y, paddle_z, depth_updated, saturated, input ready);
	modport sink (input valid, paddle_y, paddle_z, depth_updated, saturated, output ready);
endinterface

interface wepm_cfg_if #(parameter int DW = wepm_pkg::HALF_W);
	logic                               valid;
	logic                               ready;
	logic [wepm_pkg::CFG_IDX_W-1:0]     addr;
	logic [DW-1:0]                      data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

### src/windowed_ewma_position_mapper.sv
// a tracked transaction runs through window accumulation, the y and x smoothing divisions and the y mapping,
// plus the z mapping in 3d mode; the window holds DEPTH = MAX_SAMPLES - 1 samples
// a zero marker span skips that axis's division
// one item at a time: the window rotation and the shared bit-serial divider serve each item in turn;
// the next transaction is taken in the cycle after the result is loaded,
// later while the output register still holds an unaccepted result
// untracked transactions are accepted without leaving idle and give no result
// arst_n clears the sample count, the control state and loads the register defaults
module windowed_ewma_position_mapper import wepm_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	wepm_in_if.sink    in_ch,
	wepm_out_if.source out_ch,
	wepm_cfg_if.sink   cfg_ch
);

	localparam int SB    = SAMPLE_BITS;
	localparam int DEPTH = MAX_SAMPLES - 1;
	localparam int CW    = $clog2(MAX_SAMPLES);
	localparam int PW    = SB + WEIGHT_W + 1;
	localparam int VW    = PW + CW;
	localparam int SW    = SB + CW;
	localparam int NVW   = VW + CW + 1;
	localparam int SWW   = SW + WEIGHT_W + 1;
	localparam int NW1   = imax(NVW, SWW) + 9;
	localparam int S8W   = SB + 9;
	localparam int DFW   = SB + 10;
	localparam int MW2   = DFW + HALF_W + 2;
	localparam int SPW   = SB + 1;
	localparam int NW    = imax(NW1, MW2);
	localparam int DW    = imax(CW + WSUM_W, SPW + 8);
	localparam int QW    = SB + 10;
	localparam int RW    = QW + 2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACC, ST_DRAIN, ST_PROD, ST_LOAD, ST_DIV, ST_MAPMUL, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_SMOOTH_Y, PH_SMOOTH_X, PH_MAP_Y, PH_MAP_Z
	} phase_t;

	state_t  state_q;
	phase_t  phase_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          vld_s1;
	logic          out_valid_q;

	logic signed [SB-1:0] tly_q, bry_q, tlx_q, brx_q;
	logic [HALF_W-1:0]    hh_q, hd_q;
	logic                 three_d_q;

	logic in_acc, trk_acc, out_load, fin, map_ph, div_start, div_done, div_ovf;
	logic [QW-1:0] div_quo;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	cell_ctl_t     cell_ctl;

	logic signed [SB-1:0] cx [DEPTH];
	logic signed [SB-1:0] cy [DEPTH];
	logic signed [SB-1:0] px [DEPTH];
	logic signed [SB-1:0] py [DEPTH];
	logic signed [SB-1:0] nx [DEPTH];
	logic signed [SB-1:0] ny [DEPTH];

	// datapath registers
	logic signed [PW-1:0]  prod_x_s1, prod_y_s1;
	logic signed [SB-1:0]  smp_x_s1, smp_y_s1;
	logic signed [VW-1:0]  vacc_x_q, vacc_y_q;
	logic signed [SW-1:0]  sacc_x_q, sacc_y_q;
	logic signed [NVW-1:0] nv_x_s2, nv_y_s2;
	logic signed [SWW-1:0] sw_x_s2, sw_y_s2;
	logic signed [S8W-1:0] s8x_q, s8y_q;
	logic signed [MW2-1:0] mprod_s2;
	logic                  div_neg_q;
	logic signed [OUT_W-1:0] pdy_q, pdz_q;
	logic                  sat_q;
	logic signed [OUT_W-1:0] o_y_q, o_z_q;
	logic                  o_dep_q, o_sat_q;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign trk_acc = in_acc && in_ch.tracked;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);
	assign map_ph   = (phase_q == PH_MAP_Y) || (phase_q == PH_MAP_Z);

	// window: newest sample in cell 0, age grows along the chain
	assign cell_ctl.en  = trk_acc || (state_q == ST_ACC);
	assign cell_ctl.rot = (state_q == ST_ACC);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign px[i] = in_ch.hand_x;
			assign py[i] = in_ch.hand_y;
		end else begin : g_body
			assign px[i] = cx[i-1];
			assign py[i] = cy[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign nx[i] = cx[0];
			assign ny[i] = cy[0];
		end else begin : g_mid
			assign nx[i] = cx[i+1];
			assign ny[i] = cy[i+1];
		end
		wepm_cell #(.SB(SB)) u_cell (
			.clk   (clk),
			.ctl   (cell_ctl),
			.prv_x (px[i]),
			.prv_y (py[i]),
			.nxt_x (nx[i]),
			.nxt_y (ny[i]),
			.x_q   (cx[i]),
			.y_q   (cy[i])
		);
	end

	// mapping operand selection
	logic signed [S8W-1:0] s8_sel;
	logic signed [SB-1:0]  ref_sel;
	logic signed [SPW-1:0] span_sel;
	logic [SPW-1:0]        span_mag;
	logic [HALF_W-1:0]     h_sel;
	logic signed [DFW-1:0] diff;
	logic                  span_zero;

	always_comb begin
		if (phase_q == PH_MAP_Z) begin
			s8_sel   = s8x_q;
			ref_sel  = tlx_q;
			span_sel = SPW'(tlx_q) - SPW'(brx_q);
			h_sel    = hd_q;
		end else begin
			s8_sel   = s8y_q;
			ref_sel  = bry_q;
			span_sel = SPW'(tly_q) - SPW'(bry_q);
			h_sel    = hh_q;
		end
		diff      = DFW'(s8_sel) - (DFW'(ref_sel) <<< 8);
		span_zero = (span_sel == '0);
		span_mag  = span_sel[SPW-1] ? SPW'(-span_sel) : SPW'(span_sel);
	end

	// divider operands
	logic signed [NW1-1:0] num1;
	logic [NW1-1:0]        num1_mag;
	logic [MW2-1:0]        mprod_mag;
	logic [CW+WSUM_W-1:0]  den1;

	always_comb begin
		if (phase_q == PH_SMOOTH_X) begin
			num1 = (NW1'(nv_x_s2) + NW1'(sw_x_s2)) <<< 8;
		end else begin
			num1 = (NW1'(nv_y_s2) + NW1'(sw_y_s2)) <<< 8;
		end
		num1_mag  = num1[NW1-1] ? NW1'(-num1) : NW1'(num1);
		mprod_mag = mprod_s2[MW2-1] ? MW2'(-mprod_s2) : MW2'(mprod_s2);
		den1      = (CW + WSUM_W)'(cnt_q) * (CW + WSUM_W)'(WSUM_TAB[TAB_IW'(cnt_q)]);
		if (map_ph) begin
			div_num = NW'(mprod_mag);
			div_den = DW'({span_mag, 8'b0});
		end else begin
			div_num = NW'(num1_mag);
			div_den = DW'(den1);
		end
	end

	assign div_start = (state_q == ST_LOAD) && !(map_ph && span_zero);

	wepm_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.ovf    (div_ovf)
	);

	// signed quotient and coordinate saturation
	logic signed [RW-1:0]    qs;
	logic signed [RW-1:0]    rc;
	logic signed [OUT_W-1:0] map_val;
	logic                    map_sat;

	always_comb begin
		qs = div_neg_q ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
		rc = qs - $signed({{(RW - HALF_W){1'b0}}, h_sel});
		map_sat = 1'b1;
		if (span_zero) begin
			map_val = diff[DFW-1] ? OUT_MIN : OUT_MAX;
		end else if (div_ovf) begin
			map_val = div_neg_q ? OUT_MIN : OUT_MAX;
		end else if (rc > RW'(32767)) begin
			map_val = OUT_MAX;
		end else if (rc < RW'(-32768)) begin
			map_val = OUT_MIN;
		end else begin
			map_val = OUT_W'(rc);
			map_sat = 1'b0;
		end
	end

	assign fin = ((state_q == ST_LOAD) && map_ph && span_zero) ||
	             ((state_q == ST_DIV) && div_done);

	// control, configuration and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SMOOTH_Y;
			cnt_q       <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			tly_q       <= SB'(500);
			bry_q       <= SB'(-500);
			tlx_q       <= SB'(-500);
			brx_q       <= SB'(500);
			hh_q        <= HALF_W'(2560);
			hd_q        <= HALF_W'(2560);
			three_d_q   <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				unique case (cfg_reg_t'(cfg_ch.addr))
					REG_TOP_LEFT_Y:     tly_q     <= cfg_ch.data[SB-1:0];
					REG_BOTTOM_RIGHT_Y: bry_q     <= cfg_ch.data[SB-1:0];
					REG_TOP_LEFT_X:     tlx_q     <= cfg_ch.data[SB-1:0];
					REG_BOTTOM_RIGHT_X: brx_q     <= cfg_ch.data[SB-1:0];
					REG_HALF_HEIGHT:    hh_q      <= cfg_ch.data[HALF_W-1:0];
					REG_HALF_DEPTH:     hd_q      <= cfg_ch.data[HALF_W-1:0];
					REG_THREE_D_MODE:   three_d_q <= cfg_ch.data[0];
					default: ;
				endcase
			end

			vld_s1 <= (state_q == ST_ACC) && (idx_q < cnt_q);

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (trk_acc) begin
						if (cnt_q < CW'(DEPTH)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						idx_q   <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_PROD;
				ST_PROD: begin
					phase_q <= PH_SMOOTH_Y;
					state_q <= ST_LOAD;
				end
				ST_LOAD, ST_DIV: begin
					if (state_q == ST_LOAD && !fin) begin
						state_q <= ST_DIV;
					end else if (fin) begin
						unique case (phase_q)
							PH_SMOOTH_Y: begin
								phase_q <= PH_SMOOTH_X;
								state_q <= ST_LOAD;
							end
							PH_SMOOTH_X: begin
								phase_q <= PH_MAP_Y;
								state_q <= ST_MAPMUL;
							end
							PH_MAP_Y: begin
								if (three_d_q) begin
									phase_q <= PH_MAP_Z;
									state_q <= ST_MAPMUL;
								end else begin
									state_q <= ST_OUT;
								end
							end
							PH_MAP_Z: state_q <= ST_OUT;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MAPMUL: state_q <= ST_LOAD;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_x_s1 <= cx[0] * $signed({1'b0, WEIGHT_TAB[TAB_IW'(idx_q)]});
		prod_y_s1 <= cy[0] * $signed({1'b0, WEIGHT_TAB[TAB_IW'(idx_q)]});
		smp_x_s1  <= cx[0];
		smp_y_s1  <= cy[0];

		if (trk_acc) begin
			vacc_x_q <= '0;
			vacc_y_q <= '0;
			sacc_x_q <= '0;
			sacc_y_q <= '0;
			pdz_q    <= '0;
			sat_q    <= 1'b0;
		end else if (vld_s1) begin
			vacc_x_q <= vacc_x_q + VW'(prod_x_s1);
			vacc_y_q <= vacc_y_q + VW'(prod_y_s1);
			sacc_x_q <= sacc_x_q + SW'(smp_x_s1);
			sacc_y_q <= sacc_y_q + SW'(smp_y_s1);
		end

		if (state_q == ST_PROD) begin
			nv_x_s2 <= $signed({1'b0, cnt_q}) * vacc_x_q;
			nv_y_s2 <= $signed({1'b0, cnt_q}) * vacc_y_q;
			sw_x_s2 <= sacc_x_q * $signed({1'b0, WEIGHT_TAB[TAB_IW'(cnt_q)]});
			sw_y_s2 <= sacc_y_q * $signed({1'b0, WEIGHT_TAB[TAB_IW'(cnt_q)]});
		end

		if (state_q == ST_MAPMUL) begin
			mprod_s2 <= $signed({1'b0, h_sel, 1'b0}) * diff;
		end

		if (div_start) begin
			div_neg_q <= map_ph ? (mprod_s2[MW2-1] ^ span_sel[SPW-1]) : num1[NW1-1];
		end

		if (fin) begin
			case (phase_q)
				PH_SMOOTH_Y: s8y_q <= S8W'(qs);
				PH_SMOOTH_X: s8x_q <= S8W'(qs);
				PH_MAP_Y: begin
					pdy_q <= map_val;
					sat_q <= sat_q | map_sat;
				end
				default: begin
					pdz_q <= map_val;
					sat_q <= sat_q | map_sat;
				end
			endcase
		end

		if (out_load) begin
			o_y_q   <= pdy_q;
			o_z_q   <= pdz_q;
			o_dep_q <= three_d_q;
			o_sat_q <= sat_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.paddle_y      = o_y_q;
	assign out_ch.paddle_z      = o_z_q;
	assign out_ch.depth_updated = o_dep_q;
	assign out_ch.saturated     = o_sat_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("sample count beyond window depth");

	a_trk_starts: assert property (@(posedge clk) disable iff (!arst_n)
		trk_acc |=> (state_q == ST_ACC))
		else $error("tracked transaction did not start accumulation");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside of divide state");

	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result register not marked valid after load");

endmodule

### src/wepm_cell.sv
// one window cell: holds an x/y sample pair, loads from either neighbor
// depends on wepm_pkg (cell_ctl_t)
module wepm_cell import wepm_pkg::*; #(
	parameter int SB = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  cell_ctl_t            ctl,
	input  logic signed [SB-1:0] prv_x,
	input  logic signed [SB-1:0] prv_y,
	input  logic signed [SB-1:0] nxt_x,
	input  logic signed [SB-1:0] nxt_y,
	output logic signed [SB-1:0] x_q,
	output logic signed [SB-1:0] y_q
);

	// shift toward the tail on a new sample, rotate toward the head while reading
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			x_q <= ctl.rot ? nxt_x : prv_x;
			y_q <= ctl.rot ? nxt_y : prv_y;
		end
	end

endmodule

### src/wepm_div.sv
// restoring divider, one quotient bit a cycle, rounds half away from zero on magnitudes
// depends on wepm_pkg (imax)
module wepm_div import wepm_pkg::*; #(
	parameter int NW = 48,
	parameter int DW = 25,
	parameter int QW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	localparam int CMPW = imax(NW + 1, DW + QW) + 1;
	localparam int CNTW = $clog2(QW + 1);

	logic [CMPW-1:0] rem_q;
	logic [CMPW-1:0] dsh_q;
	logic [QW-1:0]   quo_q;
	logic            ovf_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [CMPW-1:0] num_rnd;

	assign num_rnd = CMPW'(num) + CMPW'(den >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNTW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_rnd;
			dsh_q <= CMPW'(den) << (QW - 1);
			ovf_q <= num_rnd >= (CMPW'(den) << QW);
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

endmodule

### bench/tb_windowed_ewma_position_mapper.sv
// testbench for the windowed ewma position mapper: smoothing predictor, stimulus and checking
// depends on wepm_pkg, the channel interfaces in src/wepm_if.sv and the mapper rtl
module tb_windowed_ewma_position_mapper;
	import wepm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = MAX_SAMPLES_DEF - 1;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [15:0] paddle_y;
		logic signed [15:0] paddle_z;
		logic               depth_updated;
		logic               saturated;
	} paddle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	wepm_in_if  in_ch();
	wepm_out_if out_ch();
	wepm_cfg_if cfg_ch();

	windowed_ewma_position_mapper uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// predictor state
	longint x_hist[DEPTH];
	longint y_hist[DEPTH];
	int     hist_len;
	longint tly, bry, tlx, brx, hh, hd;
	bit     mode_3d;

	paddle_t expected_paddles[$];
	int      errors;
	int      idle_cycles;
	bit      hold_off;
	bit      hold_req;
	int      gap_max;

	function automatic longint round_div(longint a, longint b);
		longint ua, ub, q;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		q = (ua + ub / 2) / ub;
		return ((a < 0) != (b < 0)) ? -q : q;
	endfunction

	function automatic longint smooth_axis(longint win[DEPTH], int n);
		longint w[DEPTH + 2];
		longint wsum, v, s;
		w[0] = 65536;
		wsum = 0;
		v = 0;
		s = 0;
		for (int k = 1; k <= n; k++) w[k] = (w[k-1] * 9 + 5) / 10;
		for (int k = 0; k <= n; k++) wsum += w[k];
		for (int k = 0; k < n; k++) begin
			v += win[k] * w[n - 1 - k];
			s += win[k];
		end
		return round_div((n * v + s * w[n]) * 256, n * wsum);
	endfunction

	function automatic longint map_axis(longint s8, longint ref_mm, longint span,
			longint half, ref bit sat);
		longint q;
		if (span == 0) begin
			sat = 1'b1;
			return (s8 >= ref_mm * 256) ? 32767 : -32768;
		end
		q = round_div(2 * half * (s8 - ref_mm * 256), span * 256) - half;
		if (q > 32767) begin
			sat = 1'b1;
			return 32767;
		end
		if (q < -32768) begin
			sat = 1'b1;
			return -32768;
		end
		return q;
	endfunction

	function automatic void predict_paddle(logic signed [13:0] hx, logic signed [13:0] hy);
		paddle_t p;
		bit      sat;
		longint  sx, sy;
		sat = 1'b0;
		if (hist_len >= DEPTH) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				x_hist[k] = x_hist[k+1];
				y_hist[k] = y_hist[k+1];
			end
			hist_len = DEPTH - 1;
		end
		x_hist[hist_len] = hx;
		y_hist[hist_len] = hy;
		hist_len++;
		sx = smooth_axis(x_hist, hist_len);
		sy = smooth_axis(y_hist, hist_len);
		p.paddle_y = 16'(map_axis(sy, bry, tly - bry, hh, sat));
		p.paddle_z = mode_3d ? 16'(map_axis(sx, tlx, tlx - brx, hd, sat)) : 16'sd0;
		p.depth_updated = mode_3d;
		p.saturated = sat;
		expected_paddles = {expected_paddles, p};
	endfunction

	// valid drops only when a real gap follows, so back-to-back items keep it high
	task automatic random_gap();
		int n;
		if (gap_max == 0) return;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, gap_max);
		if (n == 0) return;
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_sample(bit trk, logic signed [13:0] hx, logic signed [13:0] hy);
		in_ch.valid <= 1'b1;
		in_ch.tracked <= trk;
		in_ch.hand_x <= hx;
		in_ch.hand_y <= hy;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (trk) predict_paddle(hx, hy);
		random_gap();
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_paddles.size() != 0) @(posedge clk);
		// an untracked transaction may still be in flight
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_TOP_LEFT_Y:     tly = longint'($signed(val[13:0]));
			REG_BOTTOM_RIGHT_Y: bry = longint'($signed(val[13:0]));
			REG_TOP_LEFT_X:     tlx = longint'($signed(val[13:0]));
			REG_BOTTOM_RIGHT_X: brx = longint'($signed(val[13:0]));
			REG_HALF_HEIGHT:    hh = longint'(val);
			REG_HALF_DEPTH:     hd = longint'(val);
			REG_THREE_D_MODE:   mode_3d = val[0];
			default: ;
		endcase
	endtask

	task automatic set_markers(int ty, int by, int tx, int bx, int h, int d, bit m);
		drain();
		write_reg(REG_TOP_LEFT_Y, 16'(ty));
		write_reg(REG_BOTTOM_RIGHT_Y, 16'(by));
		write_reg(REG_TOP_LEFT_X, 16'(tx));
		write_reg(REG_BOTTOM_RIGHT_X, 16'(bx));
		write_reg(REG_HALF_HEIGHT, 16'(h));
		write_reg(REG_HALF_DEPTH, 16'(d));
		write_reg(REG_THREE_D_MODE, 16'(m));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_directed_extremes();
		gap_max = 2;
		send_sample(1'b0, 14'sd0, 14'sd0);
		send_sample(1'b1, 14'sd0, 14'sd0);
		send_sample(1'b1, 14'sh1fff, 14'sh1fff);
		send_sample(1'b1, 14'sh2000, 14'sh2000);
		send_sample(1'b0, 14'sh1fff, 14'sh2000);
		for (int i = 0; i < 8; i++)
			send_sample(1'b1, (i % 2) ? 14'sh1fff : 14'sh2000, 14'(i * 300 - 1000));
		set_markers(8191, -8192, -8192, 8191, 65535, 65535, 1'b1);
		send_sample(1'b1, 14'sh2000, 14'sh1fff);
		send_sample(1'b1, 14'sh1fff, 14'sh2000);
		send_sample(1'b1, 14'sd5, -14'sd5);
	endtask

	task automatic test_zero_span();
		set_markers(100, 100, 40, 40, 2560, 2560, 1'b1);
		send_sample(1'b1, 14'sd39, 14'sd101);
		send_sample(1'b1, 14'sd41, 14'sd99);
		send_sample(1'b1, -14'sd300, -14'sd300);
		set_markers(-8192, -8192, 8191, 8191, 0, 0, 1'b0);
		send_sample(1'b1, 14'sd0, 14'sd0);
	endtask

	task automatic test_random_tracking(int count, int gmax);
		logic signed [13:0] hx, hy;
		int cx, cy;
		gap_max = gmax;
		cx = $urandom_range(0, 2000) - 1000;
		cy = $urandom_range(0, 2000) - 1000;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				// smooth hand motion near the markers
				cx = cx + $urandom_range(0, 100) - 50;
				cy = cy + $urandom_range(0, 100) - 50;
				hx = 14'(cx);
				hy = 14'(cy);
			end else begin
				hx = 14'($urandom);
				hy = 14'($urandom);
			end
			send_sample($urandom_range(0, 7) != 0, hx, hy);
		end
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 5; ph++) begin
			set_markers($urandom_range(0, 2000) - 500, $urandom_range(0, 2000) - 1500,
				$urandom_range(0, 2000) - 1500, $urandom_range(0, 2000) - 500,
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1));
			test_random_tracking(80, (ph % 2) ? 0 : 6);
		end
		set_markers(500, -500, -500, 500, 2560, 2560, 1'b1);
		hold_req = 1'b1;
		test_random_tracking(60, 0);
		hold_req = 1'b0;
		test_random_tracking(60, 4);
	endtask

	// result side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_off) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 3) != 0) || (gap_max == 0);
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_req);
		hold_off = 1'b1;
		repeat (2000) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		paddle_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_paddles.size() == 0) begin
				$error("unexpected transaction y=%0d z=%0d", out_ch.paddle_y, out_ch.paddle_z);
				errors++;
			end else begin
				e = expected_paddles[0];
				expected_paddles.delete(0);
				if (out_ch.paddle_y !== e.paddle_y) begin
					$error("paddle_y exp %0d got %0d", e.paddle_y, out_ch.paddle_y);
					errors++;
				end
				if (out_ch.paddle_z !== e.paddle_z) begin
					$error("paddle_z exp %0d got %0d", e.paddle_z, out_ch.paddle_z);
					errors++;
				end
				if (out_ch.depth_updated !== e.depth_updated) begin
					$error("depth_updated exp %0b got %0b", e.depth_updated, out_ch.depth_updated);
					errors++;
				end
				if (out_ch.saturated !== e.saturated) begin
					$error("saturated exp %0b got %0b", e.saturated, out_ch.saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_req = 1'b0;
		gap_max = 2;
		hist_len = 0;
		tly = 500;
		bry = -500;
		tlx = -500;
		brx = 500;
		hh = 2560;
		hd = 2560;
		mode_3d = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.tracked = 1'b0;
		in_ch.hand_x = '0;
		in_ch.hand_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_zero_span();
		test_random_settings();
		drain();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
